>>> hw/rtl/nec_ir_frame_encoder_unit_macros.svh
// Assertion macros used by the checker file.
`ifndef NEC_IR_FRAME_ENCODER_UNIT_MACROS_SVH
`define NEC_IR_FRAME_ENCODER_UNIT_MACROS_SVH

// Property checked outside reset.
`define NEC_ASSERT_ON(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("nec_ir check failed");

// Property checked at every edge, reset included.
`define NEC_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("nec_ir check failed");

`endif

>>> hw/rtl/nec_ir_pkg.sv
package nec_ir_pkg;

  localparam int unsigned DUR_W       = 15;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned PULSE_IDX_W = 6;
  localparam int unsigned BYTE_W      = 8;

  // Pulse index of the stop mark for each frame kind.
  localparam logic [PULSE_IDX_W-1:0] FULL_STOP_IDX   = PULSE_IDX_W'(33);
  localparam logic [PULSE_IDX_W-1:0] REPEAT_STOP_IDX = PULSE_IDX_W'(1);

  typedef logic [DUR_W-1:0] dur_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEADER_MARK  = 3'd0,
    REG_HEADER_SPACE = 3'd1,
    REG_REPEAT_SPACE = 3'd2,
    REG_BIT_MARK     = 3'd3,
    REG_ZERO_SPACE   = 3'd4,
    REG_ONE_SPACE    = 3'd5
  } cfg_reg_e;

  localparam dur_t RST_HEADER_MARK  = dur_t'(16'h2328);
  localparam dur_t RST_HEADER_SPACE = dur_t'(16'h0fa0);
  localparam dur_t RST_REPEAT_SPACE = dur_t'(16'h08ca);
  localparam dur_t RST_BIT_MARK     = dur_t'(16'h0233);
  localparam dur_t RST_ZERO_SPACE   = dur_t'(16'h0233);
  localparam dur_t RST_ONE_SPACE    = dur_t'(16'h0698);

  typedef struct packed {
    dur_t header_mark;
    dur_t header_space;
    dur_t repeat_space;
    dur_t bit_mark;
    dur_t zero_space;
    dur_t one_space;
  } timing_t;

  typedef struct packed {
    dur_t mark;
    dur_t space;
    logic has_space;
    logic last;
  } pulse_t;

  // Handshake between pulse sequencer and output stage.
  typedef struct packed {
    logic   valid;
    pulse_t pulse;
  } pulse_req_t;

endpackage

>>> hw/rtl/nec_ir_cfg_regs.sv
module nec_ir_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [nec_ir_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nec_ir_pkg::DUR_W-1:0]     cfg_wdata,
  output nec_ir_pkg::timing_t              timing
);
  import nec_ir_pkg::*;

  timing_t timing_r;
  timing_t timing_nxt;

  always_comb begin
    timing_nxt = timing_r;
    if (cfg_wr_en) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_HEADER_MARK:  timing_nxt.header_mark  = cfg_wdata;
        REG_HEADER_SPACE: timing_nxt.header_space = cfg_wdata;
        REG_REPEAT_SPACE: timing_nxt.repeat_space = cfg_wdata;
        REG_BIT_MARK:     timing_nxt.bit_mark     = cfg_wdata;
        REG_ZERO_SPACE:   timing_nxt.zero_space   = cfg_wdata;
        REG_ONE_SPACE:    timing_nxt.one_space    = cfg_wdata;
        default:          timing_nxt = timing_r;  // unused index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timing_r.header_mark  <= RST_HEADER_MARK;
      timing_r.header_space <= RST_HEADER_SPACE;
      timing_r.repeat_space <= RST_REPEAT_SPACE;
      timing_r.bit_mark     <= RST_BIT_MARK;
      timing_r.zero_space   <= RST_ZERO_SPACE;
      timing_r.one_space    <= RST_ONE_SPACE;
    end else begin
      timing_r <= timing_nxt;
    end
  end

  assign timing = timing_r;

endmodule

>>> hw/rtl/nec_ir_seq.sv
module nec_ir_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [nec_ir_pkg::BYTE_W-1:0] in_device_address,
  input  logic [nec_ir_pkg::BYTE_W-1:0] in_key_code,
  input  logic                          in_repeat_frame,
  input  nec_ir_pkg::timing_t           timing,
  output nec_ir_pkg::pulse_req_t        req,
  input  logic                          req_ready
);
  import nec_ir_pkg::*;

  logic                   busy_r, busy_nxt;
  logic [PULSE_IDX_W-1:0] idx_r, idx_nxt;
  logic [BYTE_W-1:0]      addr_r, key_r;
  logic                   rep_r;

  logic [4*BYTE_W-1:0]    data_word;
  logic [PULSE_IDX_W-1:0] bit_pos;
  logic                   is_header, is_stop, data_bit;
  logic                   advance, in_xfer;
  pulse_t                 pulse;

  // Frame bits in transmit order, LSB first.
  assign data_word = {~key_r, key_r, ~addr_r, addr_r};
  assign bit_pos   = idx_r - PULSE_IDX_W'(1);
  assign data_bit  = data_word[bit_pos[4:0]];
  assign is_header = (idx_r == '0);
  assign is_stop   = rep_r ? (idx_r == REPEAT_STOP_IDX) : (idx_r == FULL_STOP_IDX);

  always_comb begin
    pulse.last      = is_stop;
    pulse.has_space = !is_stop;
    if (is_header) begin
      pulse.mark  = timing.header_mark;
      pulse.space = rep_r ? timing.repeat_space : timing.header_space;
    end else if (is_stop) begin
      pulse.mark  = timing.bit_mark;
      pulse.space = '0;
    end else begin
      pulse.mark  = timing.bit_mark;
      pulse.space = data_bit ? timing.one_space : timing.zero_space;
    end
  end

  assign req.valid = busy_r;
  assign req.pulse = pulse;

  assign advance  = busy_r && req_ready;
  // Next frame loads while the stop mark moves out.
  assign in_ready = !busy_r || (advance && is_stop);
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (in_xfer) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end else if (advance) begin
      busy_nxt = !is_stop;
      idx_nxt  = idx_r + PULSE_IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      addr_r <= in_device_address;
      key_r  <= in_key_code;
      rep_r  <= in_repeat_frame;
    end
  end

endmodule

>>> hw/rtl/nec_ir_out_stage.sv
module nec_ir_out_stage (
  input  logic                         clk,
  input  logic                         rst_n,
  input  nec_ir_pkg::pulse_req_t       req,
  output logic                         req_ready,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [nec_ir_pkg::DUR_W-1:0] out_mark_us,
  output logic [nec_ir_pkg::DUR_W-1:0] out_space_us,
  output logic                         out_has_space,
  output logic                         out_last_pulse
);
  import nec_ir_pkg::*;

  logic   valid_r, valid_nxt;
  pulse_t pulse_r;

  assign req_ready = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (req_ready) begin
      valid_nxt = req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req.valid) begin
      pulse_r <= req.pulse;
    end
  end

  assign out_valid      = valid_r;
  assign out_mark_us    = pulse_r.mark;
  assign out_space_us   = pulse_r.space;
  assign out_has_space  = pulse_r.has_space;
  assign out_last_pulse = pulse_r.last;

endmodule

>>> hw/rtl/nec_ir_frame_encoder_unit.sv
// NEC infrared frame encoder. Each input transfer (address, key code, repeat
// flag) becomes a train of mark/space pulses in microseconds, one pulse per
// output transfer: a full frame gives 34 pulses (header, 32 data bits LSB
// first as address, ~address, key, ~key, then the stop mark), a repeat frame
// gives 2 (header with the repeat space, stop mark). The pulse sequencer
// issues one pulse per cycle into a single output register while the output
// is not stalled; the next input is taken in the cycle its predecessor's
// stop mark enters the output register, so frames stream without gaps. The
// six timing registers reset to 9000/4000/2250/563/563/1688 us and are
// written through cfg_wr_en/cfg_index/cfg_wdata; the user must write them
// only while the block is idle, which the block itself does not enforce;
// writes to indexes 6 and 7 are ignored.
module nec_ir_frame_encoder_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [nec_ir_pkg::BYTE_W-1:0]    in_device_address,
  input  logic [nec_ir_pkg::BYTE_W-1:0]    in_key_code,
  input  logic                             in_repeat_frame,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [nec_ir_pkg::DUR_W-1:0]     out_mark_us,
  output logic [nec_ir_pkg::DUR_W-1:0]     out_space_us,
  output logic                             out_has_space,
  output logic                             out_last_pulse,
  input  logic                             cfg_wr_en,
  input  logic [nec_ir_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nec_ir_pkg::DUR_W-1:0]     cfg_wdata
);
  import nec_ir_pkg::*;

  timing_t    timing;
  pulse_req_t req;
  logic       req_ready;

  nec_ir_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .timing    (timing)
  );

  nec_ir_seq u_seq (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_device_address (in_device_address),
    .in_key_code       (in_key_code),
    .in_repeat_frame   (in_repeat_frame),
    .timing            (timing),
    .req               (req),
    .req_ready         (req_ready)
  );

  nec_ir_out_stage u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .req            (req),
    .req_ready      (req_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_mark_us    (out_mark_us),
    .out_space_us   (out_space_us),
    .out_has_space  (out_has_space),
    .out_last_pulse (out_last_pulse)
  );

endmodule

>>> hw/rtl/nec_ir_checker.sv
`include "nec_ir_frame_encoder_unit_macros.svh"

module nec_ir_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [nec_ir_pkg::DUR_W-1:0] out_mark_us,
  input logic [nec_ir_pkg::DUR_W-1:0] out_space_us,
  input logic                         out_has_space,
  input logic                         out_last_pulse
);
  import nec_ir_pkg::*;

  logic [2*DUR_W+1:0] out_bundle;

  assign out_bundle = {out_mark_us, out_space_us, out_has_space, out_last_pulse};

  // Stalled result holds.
  `NEC_ASSERT_ON(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_bundle))

  // Stop mark carries no space, and only the stop mark lacks one.
  `NEC_ASSERT_ON(a_stop_shape, out_valid |-> (out_last_pulse == !out_has_space))
  `NEC_ASSERT_ON(a_stop_zero, out_valid && out_last_pulse |-> out_space_us == '0)

  // Nothing is offered in the cycle after reset.
  `NEC_ASSERT_ALWAYS(a_rst_idle, !rst_n |=> !out_valid)

endmodule

bind nec_ir_frame_encoder_unit nec_ir_checker u_nec_ir_checker (.*);

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import nec_ir_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned HOLD_CYCLES = 500;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;
  localparam dur_t DUR_MAX = dur_t'(32767);

  class pulse_book;
    timing_t tmg;
    pulse_t  pending_pulses[$];
    int unsigned errors;
    int unsigned frames;
    int unsigned pulses;

    function new();
      tmg = '{RST_HEADER_MARK, RST_HEADER_SPACE, RST_REPEAT_SPACE,
              RST_BIT_MARK, RST_ZERO_SPACE, RST_ONE_SPACE};
      errors = 0;
      frames = 0;
      pulses = 0;
    endfunction

    function void set_timing(logic [CFG_IDX_W-1:0] index, dur_t value);
      case (index)
        REG_HEADER_MARK:  tmg.header_mark  = value;
        REG_HEADER_SPACE: tmg.header_space = value;
        REG_REPEAT_SPACE: tmg.repeat_space = value;
        REG_BIT_MARK:     tmg.bit_mark     = value;
        REG_ZERO_SPACE:   tmg.zero_space   = value;
        REG_ONE_SPACE:    tmg.one_space    = value;
        default: ;
      endcase
    endfunction

    // Accepted input transfer: queue the pulse train it should produce.
    function void add_frame_pulses(logic [7:0] addr, logic [7:0] key, logic rep);
      logic [31:0] word;
      frames++;
      if (rep) begin
        pending_pulses.push_back('{tmg.header_mark, tmg.repeat_space, 1'b1, 1'b0});
      end else begin
        pending_pulses.push_back('{tmg.header_mark, tmg.header_space, 1'b1, 1'b0});
        word = {~key, key, ~addr, addr};
        for (int i = 0; i < 32; i++)
          pending_pulses.push_back('{tmg.bit_mark,
                                     word[i] ? tmg.one_space : tmg.zero_space,
                                     1'b1, 1'b0});
      end
      pending_pulses.push_back('{tmg.bit_mark, dur_t'(0), 1'b0, 1'b1});
    endfunction

    task report(string what, int unsigned got, int unsigned want);
      $display("[%0t] mismatch on %s: got %0d, want %0d (pulse %0d)",
               $realtime, what, got, want, pulses);
      errors++;
    endtask

    task check_pulse(pulse_t got);
      pulse_t want;
      if (pending_pulses.size() == 0) begin
        report("unexpected pulse, mark", got.mark, 0);
      end else begin
        want = pending_pulses.pop_front();
        if (got.mark !== want.mark) report("mark_us", got.mark, want.mark);
        if (got.space !== want.space) report("space_us", got.space, want.space);
        if (got.has_space !== want.has_space)
          report("has_space", got.has_space, want.has_space);
        if (got.last !== want.last) report("last_pulse", got.last, want.last);
      end
      pulses++;
    endtask

    function int unsigned pending();
      return pending_pulses.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [BYTE_W-1:0]    in_device_address = '0;
  logic [BYTE_W-1:0]    in_key_code = '0;
  logic                 in_repeat_frame = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [DUR_W-1:0]     out_mark_us;
  logic [DUR_W-1:0]     out_space_us;
  logic                 out_has_space;
  logic                 out_last_pulse;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DUR_W-1:0]     cfg_wdata = '0;

  pulse_book book = new();
  bit steady = 1'b0;
  bit hold_req = 1'b0;
  int unsigned settings = 0;
  int unsigned cycles = 0;

  nec_ir_frame_encoder_unit uut (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_device_address, .in_key_code, .in_repeat_frame,
    .out_valid, .out_ready, .out_mark_us, .out_space_us, .out_has_space,
    .out_last_pulse,
    .cfg_wr_en, .cfg_index, .cfg_wdata
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (steady || r < 10) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function dur_t pick_dur();
    case ($urandom_range(0, 9))
      0: return DUR_MAX;
      1: return dur_t'(1);
      default: return dur_t'($urandom_range(1, 32767));
    endcase
  endfunction

  // Output side: random stalls, plus one long hold-off on request.
  initial begin
    int unsigned stall_cnt;
    stall_cnt = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        stall_cnt = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (stall_cnt != 0) begin
        stall_cnt--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 5) == 0) stall_cnt = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      book.check_pulse('{out_mark_us, out_space_us, out_has_space, out_last_pulse});
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d pulses outstanding", cycles, book.pending());
    $display("*** FAILED ***");
    $finish;
  end

  // Leaves valid high after the transfer; the next call lowers it or reuses it.
  task send_frame(logic [7:0] addr, logic [7:0] key, logic rep);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_device_address <= addr;
    in_key_code <= key;
    in_repeat_frame <= rep;
    do @(posedge clk); while (!in_ready);
    book.add_frame_pulses(addr, key, rep);
  endtask

  task send_random(int unsigned n);
    for (int i = 0; i < n; i++)
      send_frame(8'($urandom), 8'($urandom), $urandom_range(0, 3) == 0);
  endtask

  task wait_idle();
    in_valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task write_reg(logic [CFG_IDX_W-1:0] index, dur_t value);
    cfg_wr_en <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
    book.set_timing(index, value);
  endtask

  task write_all(dur_t hm, dur_t hs, dur_t rs, dur_t bm, dur_t zs, dur_t os);
    write_reg(REG_HEADER_MARK, hm);
    write_reg(REG_HEADER_SPACE, hs);
    write_reg(REG_REPEAT_SPACE, rs);
    write_reg(REG_BIT_MARK, bm);
    write_reg(REG_ZERO_SPACE, zs);
    write_reg(REG_ONE_SPACE, os);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    settings++;
  endtask

  task write_random();
    write_all(pick_dur(), pick_dur(), pick_dur(), pick_dur(), pick_dur(), pick_dur());
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset timings, field extremes and bit patterns
    send_frame(8'h00, 8'h00, 1'b0);
    send_frame(8'hff, 8'hff, 1'b0);
    send_frame(8'h01, 8'h80, 1'b0);
    send_frame(8'ha5, 8'h5a, 1'b0);
    send_frame(8'hff, 8'hff, 1'b1);
    send_frame(8'h00, 8'h00, 1'b1);
    send_frame(8'h80, 8'h01, 1'b0);
    wait_idle();

    write_all(DUR_MAX, DUR_MAX, DUR_MAX, DUR_MAX, DUR_MAX, DUR_MAX);
    send_frame(8'h3c, 8'hc3, 1'b0);
    send_frame(8'h12, 8'h34, 1'b1);
    wait_idle();

    // zero durations pass straight through
    write_all('0, '0, '0, '0, '0, '0);
    send_frame(8'h0f, 8'hf0, 1'b0);
    send_frame(8'hf0, 8'h0f, 1'b1);
    wait_idle();

    // distinct small values; spare indexes must not disturb anything
    write_all(dur_t'(1), dur_t'(2), dur_t'(3), dur_t'(4), dur_t'(5), dur_t'(6));
    write_reg(IDX_SPARE_LO, DUR_MAX);
    write_reg(IDX_SPARE_HI, dur_t'(12345));
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    send_frame(8'h55, 8'haa, 1'b0);
    send_frame(8'h55, 8'haa, 1'b1);
    send_frame(8'h00, 8'hff, 1'b0);
    wait_idle();

    // back to standard timings, random traffic
    write_all(RST_HEADER_MARK, RST_HEADER_SPACE, RST_REPEAT_SPACE,
              RST_BIT_MARK, RST_ZERO_SPACE, RST_ONE_SPACE);
    send_random(30);
    wait_idle();

    write_random();
    send_random(30);
    wait_idle();

    // no idling on either side
    write_random();
    steady = 1'b1;
    send_random(25);
    wait_idle();
    steady = 1'b0;

    // long output hold-off while frames keep coming
    write_random();
    hold_req = 1'b1;
    for (int i = 0; i < 8; i++)
      send_frame(8'($urandom), 8'($urandom), i[0] && i > 4);
    wait_idle();

    write_random();
    send_random(30);
    wait_idle();

    $display("covered %0d frames / %0d pulses across %0d timing settings",
             book.frames, book.pulses, settings);
    $display("included zero and full-scale timings, spare index writes, one %0d-cycle hold-off",
             HOLD_CYCLES);
    if (book.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", book.errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/nec_ir_pkg.sv
hw/rtl/nec_ir_cfg_regs.sv
hw/rtl/nec_ir_seq.sv
hw/rtl/nec_ir_out_stage.sv
hw/rtl/nec_ir_frame_encoder_unit.sv
hw/rtl/nec_ir_checker.sv
verif/tb_top.sv
